### src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies the consequent in the same cycle.
`define QDSCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define QDSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/qdsct_pkg.sv
`default_nettype none

package qdsct_pkg;

    localparam int CNT_W    = 5;
    localparam int GEN_W    = 32;
    localparam int ERR_W    = 8;
    localparam int PARITY_W = 4;

    localparam logic [PARITY_W-1:0] PARITY_RESET = 4'd1;

    localparam logic [ERR_W-1:0] ERR_NONE = 8'd0;
    localparam logic [ERR_W-1:0] ERR_IO   = 8'd5;
    localparam logic [ERR_W-1:0] ERR_BUSY = 8'd16;

    typedef enum logic [1:0] {
        REQ_START       = 2'd0,
        REQ_COMPLETE    = 2'd1,
        REQ_LOAD_COPY   = 2'd2,
        REQ_LOAD_FINISH = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_BUSY        = 3'd1,
        STATUS_NO_DISK     = 3'd2,
        STATUS_NOTHING     = 3'd3,
        STATUS_UNEXPECTED  = 3'd4
    } status_t;

    typedef struct packed {
        req_t             req_type;
        logic [CNT_W-1:0] writable_count;
        logic [CNT_W-1:0] submitted_count;
        logic [ERR_W-1:0] submit_error;
        logic             write_ok;
        logic             copy_valid;
        logic             copy_slot;
        logic [GEN_W-1:0] copy_generation;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic             durable_event;
        logic             drained_event;
        logic [ERR_W-1:0] result_code;
        logic             write_slot;
        logic [GEN_W-1:0] current_generation;
        logic             current_slot;
        logic             loaded;
    } result_t;

endpackage

`default_nettype wire

### src/quorum_double_slot_commit_tracker.sv
// Quorum commit tracker for double-buffered replicated metadata. The block takes one item
// per clock cycle while in_stall is low and gives exactly one result item for each. The
// accepting edge loads the input register; the result register is loaded from it after a
// single pass through the state update logic, once the result side can move. The tracker
// state is updated in that same pass, so back-to-back items see each other's effects with
// no bubbles. At most two items are held, one in each register. Once both are full, a
// stalled result stalls the input in the same cycle. The parity count register resets to
// one and may be written at any time the block is idle; cfg_ready is always high.
`default_nettype none

module quorum_double_slot_commit_tracker
    import qdsct_pkg::*;
#(
    parameter int MAX_DISKS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          req_type,
    input  wire logic [CNT_W-1:0]    writable_count,
    input  wire logic [CNT_W-1:0]    submitted_count,
    input  wire logic [ERR_W-1:0]    submit_error,
    input  wire logic                write_ok,
    input  wire logic                copy_valid,
    input  wire logic                copy_slot,
    input  wire logic [GEN_W-1:0]    copy_generation,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [2:0]               status,
    output logic                     durable_event,
    output logic                     drained_event,
    output logic [ERR_W-1:0]         result_code,
    output logic                     write_slot,
    output logic [GEN_W-1:0]         current_generation,
    output logic                     current_slot,
    output logic                     loaded,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PARITY_W-1:0] parity_count
);

    item_t   in_item;
    item_t   s1_item;
    logic    s1_valid;
    logic    can_move;
    logic    fire;
    result_t core_result;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign in_item.req_type        = req_t'(req_type);
    assign in_item.writable_count  = writable_count;
    assign in_item.submitted_count = submitted_count;
    assign in_item.submit_error    = submit_error;
    assign in_item.write_ok        = write_ok;
    assign in_item.copy_valid      = copy_valid;
    assign in_item.copy_slot       = copy_slot;
    assign in_item.copy_generation = copy_generation;

    assign can_move  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid && can_move;
    assign cfg_ready = 1'b1;

    qdsct_in_reg u_in_reg (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .downstream_ready (can_move),
        .item_valid       (s1_valid),
        .item             (s1_item)
    );

    qdsct_core #(
        .MAX_DISKS (MAX_DISKS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (parity_count),
        .fire     (fire),
        .item     (s1_item),
        .result   (core_result)
    );

    assign out_valid_next = fire ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = result_reg.status;
    assign durable_event      = result_reg.durable_event;
    assign drained_event      = result_reg.drained_event;
    assign result_code        = result_reg.result_code;
    assign write_slot         = result_reg.write_slot;
    assign current_generation = result_reg.current_generation;
    assign current_slot       = result_reg.current_slot;
    assign loaded             = result_reg.loaded;

endmodule

`default_nettype wire

### src/qdsct_in_reg.sv
`default_nettype none

module qdsct_in_reg
    import qdsct_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t in_item,
    input  wire logic  downstream_ready,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register holds its item only while the result side cannot move.
    assign in_stall   = valid_reg && !downstream_ready;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### src/qdsct_core.sv
`default_nettype none

module qdsct_core
    import qdsct_pkg::*;
#(
    parameter int MAX_DISKS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [PARITY_W-1:0] cfg_data,
    input  wire logic                fire,
    input  wire item_t               item,
    output result_t                  result
);

    logic [PARITY_W-1:0] parity_reg;

    logic             busy_reg,        busy_next;
    logic [GEN_W-1:0] gen_reg,         gen_next;
    logic             active_reg,      active_next;
    logic             pending_reg,     pending_next;
    logic [CNT_W-1:0] outstanding_reg, outstanding_next;
    logic [CNT_W-1:0] success_reg,     success_next;
    logic [CNT_W-1:0] quorum_reg,      quorum_next;
    logic             acked_reg,       acked_next;
    logic [ERR_W-1:0] first_err_reg,   first_err_next;
    logic             have_best_reg,   have_best_next;
    logic [GEN_W-1:0] best_gen_reg,    best_gen_next;
    logic             best_slot_reg,   best_slot_next;

    always_comb
    begin
        logic [CNT_W-1:0] wr_sat;
        logic [CNT_W-1:0] sub_sat;
        logic [CNT_W-1:0] q;

        busy_next        = busy_reg;
        gen_next         = gen_reg;
        active_next      = active_reg;
        pending_next     = pending_reg;
        outstanding_next = outstanding_reg;
        success_next     = success_reg;
        quorum_next      = quorum_reg;
        acked_next       = acked_reg;
        first_err_next   = first_err_reg;
        have_best_next   = have_best_reg;
        best_gen_next    = best_gen_reg;
        best_slot_next   = best_slot_reg;

        result.status        = STATUS_OK;
        result.durable_event = 1'b0;
        result.drained_event = 1'b0;
        result.result_code   = ERR_NONE;
        result.loaded        = 1'b0;

        wr_sat = item.writable_count;
        if (32'(item.writable_count) > 32'(MAX_DISKS))
        begin
            wr_sat = CNT_W'(MAX_DISKS);
        end
        sub_sat = (item.submitted_count > wr_sat) ? wr_sat : item.submitted_count;
        q       = CNT_W'(parity_reg) + CNT_W'(1);

        unique case (item.req_type)
            REQ_START:
            begin
                if (busy_reg)
                begin
                    result.status      = STATUS_BUSY;
                    result.result_code = ERR_BUSY;
                end
                else if (wr_sat == '0)
                begin
                    result.status      = STATUS_NO_DISK;
                    result.result_code = ERR_IO;
                end
                else
                begin
                    gen_next         = gen_reg + GEN_W'(1);
                    pending_next     = !active_reg;
                    quorum_next      = (wr_sat < q) ? wr_sat : q;
                    success_next     = '0;
                    acked_next       = 1'b0;
                    first_err_next   = item.submit_error;
                    outstanding_next = sub_sat;
                    // With nothing submitted the persist rolls back at once.
                    if (sub_sat == '0)
                    begin
                        busy_next          = 1'b0;
                        result.status      = STATUS_NOTHING;
                        result.result_code = (item.submit_error != ERR_NONE) ?
                                             item.submit_error : ERR_IO;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                    end
                end
            end
            REQ_COMPLETE:
            begin
                if (!busy_reg || outstanding_reg == '0)
                begin
                    result.status = STATUS_UNEXPECTED;
                end
                else
                begin
                    success_next = success_reg + CNT_W'(item.write_ok);
                    if (!item.write_ok && first_err_reg == ERR_NONE)
                    begin
                        first_err_next = ERR_IO;
                    end
                    if (!acked_reg && success_next >= quorum_reg)
                    begin
                        acked_next           = 1'b1;
                        active_next          = pending_reg;
                        result.durable_event = 1'b1;
                    end
                    outstanding_next = outstanding_reg - CNT_W'(1);
                    if (outstanding_next == '0)
                    begin
                        busy_next            = 1'b0;
                        result.drained_event = 1'b1;
                        // A persist that never reached quorum reports its error now.
                        if (!acked_next)
                        begin
                            result.durable_event = 1'b1;
                            result.result_code   = (first_err_next != ERR_NONE) ?
                                                   first_err_next : ERR_IO;
                        end
                    end
                end
            end
            REQ_LOAD_COPY:
            begin
                if (item.copy_valid && (!have_best_reg || item.copy_generation > best_gen_reg))
                begin
                    have_best_next = 1'b1;
                    best_gen_next  = item.copy_generation;
                    best_slot_next = item.copy_slot;
                end
            end
            REQ_LOAD_FINISH:
            begin
                if (have_best_reg)
                begin
                    gen_next      = best_gen_reg;
                    active_next   = best_slot_reg;
                    result.loaded = 1'b1;
                end
                have_best_next = 1'b0;
                best_gen_next  = '0;
                best_slot_next = 1'b0;
            end
            default:
            begin
                result.status = STATUS_OK;
            end
        endcase

        result.write_slot         = pending_next;
        result.current_generation = gen_next;
        result.current_slot       = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= PARITY_RESET;
        end
        else if (cfg_we)
        begin
            parity_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            gen_reg         <= '0;
            active_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            outstanding_reg <= '0;
            success_reg     <= '0;
            quorum_reg      <= '0;
            acked_reg       <= 1'b0;
            first_err_reg   <= '0;
            have_best_reg   <= 1'b0;
            best_gen_reg    <= '0;
            best_slot_reg   <= 1'b0;
        end
        else if (fire)
        begin
            busy_reg        <= busy_next;
            gen_reg         <= gen_next;
            active_reg      <= active_next;
            pending_reg     <= pending_next;
            outstanding_reg <= outstanding_next;
            success_reg     <= success_next;
            quorum_reg      <= quorum_next;
            acked_reg       <= acked_next;
            first_err_reg   <= first_err_next;
            have_best_reg   <= have_best_next;
            best_gen_reg    <= best_gen_next;
            best_slot_reg   <= best_slot_next;
        end
    end

endmodule

`default_nettype wire

### src/qdsct_checker.sv
`default_nettype none

`include "assert_macros.svh"

module qdsct_checker
    import qdsct_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic [1:0]          req_type,
    input  wire logic [CNT_W-1:0]    writable_count,
    input  wire logic [CNT_W-1:0]    submitted_count,
    input  wire logic [ERR_W-1:0]    submit_error,
    input  wire logic                write_ok,
    input  wire logic                copy_valid,
    input  wire logic                copy_slot,
    input  wire logic [GEN_W-1:0]    copy_generation,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [2:0]          status,
    input  wire logic                durable_event,
    input  wire logic                drained_event,
    input  wire logic [ERR_W-1:0]    result_code,
    input  wire logic                write_slot,
    input  wire logic [GEN_W-1:0]    current_generation,
    input  wire logic                current_slot,
    input  wire logic                loaded,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [PARITY_W-1:0] parity_count
);

    // A start refused as busy always carries the busy error code.
    `QDSCT_ASSERT_SAME(a_busy_code, clk, rst_n,
        out_valid && status == STATUS_BUSY, result_code == ERR_BUSY,
        "busy refusal without busy error code")

    // A drain that failed must also fire the durability callback with its error.
    `QDSCT_ASSERT_SAME(a_failed_drain_durable, clk, rst_n,
        out_valid && drained_event && result_code != ERR_NONE, durable_event,
        "failed drain without durable event")

    // Events and loads only come with an accepted, successful status.
    `QDSCT_ASSERT_SAME(a_events_ok_status, clk, rst_n,
        out_valid && (durable_event || drained_event || loaded), status == STATUS_OK,
        "event reported with a refusal status")

    // A stalled result stays presented.
    `QDSCT_ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && out_stall, out_valid && $stable(current_generation),
        "stalled result dropped or changed")

endmodule

bind quorum_double_slot_commit_tracker qdsct_checker u_checker (.*);

`default_nettype wire
